// ----- sv/firmware_image_verifier_defines.svh -----
// Assertion helpers for the verifier
`ifndef FIRMWARE_IMAGE_VERIFIER_DEFINES_SVH
`define FIRMWARE_IMAGE_VERIFIER_DEFINES_SVH
`define FIV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FIV_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- sv/fiv_pkg.sv -----
package fiv_pkg;
	localparam int MAX_IMAGE_BYTES_DEF = 49152;
	localparam logic [31:0] MAGIC_VALUE = 32'hDEADBEEF;
	localparam logic [31:0] SP_MASK = 32'h2FFE0000;
	localparam logic [31:0] SP_BASE = 32'h20000000;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	localparam logic [2:0] ST_PASS = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_BAD_LEN = 3'd2;
	localparam logic [2:0] ST_BAD_SP = 3'd3;
	localparam logic [2:0] ST_BAD_CRC = 3'd4;
	localparam logic [2:0] ST_BAD_DIGEST = 3'd5;

	localparam logic [2:0] REG_MAGIC = 3'd0;
	localparam logic [2:0] REG_LENGTH = 3'd1;
	localparam logic [2:0] REG_CRC = 3'd2;
	localparam logic [2:0] REG_DIG0 = 3'd3;
	localparam logic [2:0] REG_DIG1 = 3'd4;
	localparam logic [2:0] REG_DIG2 = 3'd5;
	localparam logic [2:0] REG_DIG3 = 3'd6;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] computed_crc;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_BYTE, S_PAD, S_ZERO, S_LEN_HI, S_LEN_LO,
		S_COMP, S_COMP_WAIT, S_REPORT
	} state_t;

	// control from sequencer to compression engine
	typedef struct packed {
		logic start;
		logic init;
	} cmp_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cmp_sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		crc_byte = r;
	endfunction

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		logic [31:0] k [64] = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		sha_k = k[i];
	endfunction

	function automatic logic [31:0] sha_iv(input logic [2:0] i);
		logic [31:0] v [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
			32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
		sha_iv = v[i];
	endfunction
endpackage

// ----- sv/fiv_sha_core.sv -----
// SHA-256 compression over a 16-word block, one round per cycle.
// Block words come from the sequencer's buffer memory, addressed one round
// ahead, and are written into a 16-deep schedule memory (ring of w values).
module fiv_sha_core import fiv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmp_ctl_t    ctl,
	input  logic [31:0] blk_word,
	output logic [3:0]  blk_addr,
	output cmp_sts_t    sts,
	output logic [255:0] digest
);
	logic [31:0] h_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [31:0] w_q [16];
	logic [6:0]  cnt_q;
	logic        run_q, load_q, fin_q;

	logic [31:0] w_cur, s0, s1, t1, t2, w_new;
	logic [3:0]  idx;

	assign idx = cnt_q[3:0];
	// memory read latency: word for round n is addressed during round n-1
	assign blk_addr = load_q ? 4'd0 : 4'(idx + 4'd1);

	// w for round cnt: rounds below 16 take the loaded block word
	always_comb begin
		s0 = rotr(w_q[4'(idx + 4'd1)], 7) ^ rotr(w_q[4'(idx + 4'd1)], 18)
			^ (w_q[4'(idx + 4'd1)] >> 3);
		s1 = rotr(w_q[4'(idx + 4'd14)], 17) ^ rotr(w_q[4'(idx + 4'd14)], 19)
			^ (w_q[4'(idx + 4'd14)] >> 10);
		w_new = w_q[idx] + s0 + w_q[4'(idx + 4'd9)] + s1;
		w_cur = (cnt_q < 7'd16) ? blk_word : w_new;
		t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
			+ ((e_q & f_q) ^ (~e_q & g_q)) + sha_k(cnt_q[5:0]) + w_cur;
		t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			load_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_iv(3'(i));
		end else begin
			if (ctl.init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha_iv(3'(i));
			end
			if (ctl.start) begin
				load_q <= 1'b1;
				cnt_q <= '0;
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
				e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
			end else if (load_q) begin
				// memory read latency: first word is addressed now and reaches blk_word once running
				load_q <= 1'b0;
				run_q <= 1'b1;
			end else if (run_q) begin
				w_q[idx] <= w_cur;
				hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
				d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
				h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
			end
		end
	end

	assign sts.busy = run_q | load_q | fin_q | ctl.start;
	assign sts.done = fin_q;
	assign digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
endmodule

// ----- sv/firmware_image_verifier.sv -----
// Firmware image verifier. A start beat checks magic and length and, on a
// failure, presents a result the cycle after it is taken. Each byte beat is
// read-modify-written into the 16-word block buffer memory in S_BYTE; every
// 64th byte and the final padding start a SHA-256 compression, one round per
// cycle in the shared round unit, that holds the input off until it is done.
// The final result follows the last byte after padding and one or two
// compressions. A result held by the receiver stalls input.
module firmware_image_verifier import fiv_pkg::*; #(
	parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [31:0] magic_q, len_q, ecrc_q;
	logic [63:0] dig_q [4];

	state_t state_q, state_n;
	logic [15:0] seen_q;
	logic [31:0] crc_q, first_q;
	logic [7:0]  byte_q;
	logic        busy_q, two_q;
	logic [3:0]  zi_q;
	logic [31:0] pad_q;

	logic [31:0] buf_mem [16];
	logic [31:0] rd_s1;
	logic [3:0]  rd_addr, wr_addr;
	logic [31:0] wr_data;
	logic        wr_en;

	cmp_ctl_t ctl;
	cmp_sts_t sts;
	logic [3:0] core_addr;
	logic [255:0] digest;

	logic acc, out_free, res_v;
	out_item_t res;
	logic [5:0] pos;
	logic [31:0] merged;
	logic [15:0] seen_n;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = !(state_q == S_IDLE) || !out_free;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0; len_q <= '0; ecrc_q <= '0;
			for (int i = 0; i < 4; i++) dig_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAGIC:  magic_q <= cfg_data[31:0];
				REG_LENGTH: len_q <= cfg_data[31:0];
				REG_CRC:    ecrc_q <= cfg_data[31:0];
				REG_DIG0:   dig_q[0] <= cfg_data;
				REG_DIG1:   dig_q[1] <= cfg_data;
				REG_DIG2:   dig_q[2] <= cfg_data;
				REG_DIG3:   dig_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// position in the block of the byte being placed (final pad uses seen_q)
	// the pad right after the last byte shares its word, still being written
	assign pos = seen_q[5:0];
	always_comb begin
		merged = (pos[1:0] == 2'd0) ? 32'd0 : ((state_q == S_PAD) ? pad_q : rd_s1);
		unique case (pos[1:0])
			2'd0: merged[31:24] = (state_q == S_PAD) ? 8'h80 : byte_q;
			2'd1: merged[23:16] = (state_q == S_PAD) ? 8'h80 : byte_q;
			2'd2: merged[15:8]  = (state_q == S_PAD) ? 8'h80 : byte_q;
			default: merged[7:0] = (state_q == S_PAD) ? 8'h80 : byte_q;
		endcase
	end

	assign seen_n = seen_q + 16'd1;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && in_data.operation == OP_BYTE && busy_q) state_n = S_BYTE;
			end
			S_BYTE: begin
				if (seen_q[5:0] == 6'd63) state_n = S_COMP;
				else if ({16'd0, seen_n} == len_q) state_n = S_PAD;
				else state_n = S_IDLE;
			end
			S_PAD: state_n = (pos[5:2] == 4'd15) ? S_COMP : S_ZERO;
			S_ZERO: begin
				if (zi_q == 4'd15) state_n = two_q ? S_COMP : S_LEN_HI;
			end
			S_LEN_HI: state_n = S_LEN_LO;
			S_LEN_LO: state_n = S_COMP;
			S_COMP: state_n = S_COMP_WAIT;
			S_COMP_WAIT: begin
				if (sts.done) begin
					if (!busy_q && !two_q) state_n = S_REPORT;
					else if (!busy_q && two_q) state_n = S_ZERO;
					else if ({16'd0, seen_q} == len_q) state_n = S_PAD;
					else state_n = S_IDLE;
				end
			end
			S_REPORT: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		rd_addr = pos[5:2];
		wr_en = 1'b0;
		wr_addr = pos[5:2];
		wr_data = merged;
		ctl = '0;
		if (state_q == S_COMP_WAIT || state_q == S_COMP) rd_addr = core_addr;
		unique case (state_q)
			S_BYTE, S_PAD: wr_en = 1'b1;
			S_ZERO: begin
				wr_addr = zi_q;
				wr_data = '0;
				wr_en = 1'b1;
			end
			S_LEN_HI: begin
				wr_addr = 4'd14; wr_data = 32'd0; wr_en = 1'b1;
			end
			S_LEN_LO: begin
				wr_addr = 4'd15; wr_data = {13'd0, seen_q, 3'd0}; wr_en = 1'b1;
			end
			S_COMP: ctl.start = 1'b1;
			default: ;
		endcase
		if (state_q == S_IDLE && acc && in_data.operation == OP_START) ctl.init = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) buf_mem[wr_addr] <= wr_data;
		rd_s1 <= buf_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			seen_q <= '0;
			crc_q <= ALL_ONES;
			first_q <= '0;
			two_q <= 1'b0;
			zi_q <= '0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				S_IDLE: begin
					if (acc && in_data.operation == OP_START) begin
						seen_q <= '0;
						crc_q <= ALL_ONES;
						first_q <= '0;
						busy_q <= magic_q == MAGIC_VALUE && len_q != 32'd0
							&& len_q <= 32'(MAX_IMAGE_BYTES);
					end else if (acc && busy_q) begin
						crc_q <= crc_byte(crc_q, in_data.data_byte);
						unique case (seen_q)
							16'd0: first_q[7:0] <= in_data.data_byte;
							16'd1: first_q[15:8] <= in_data.data_byte;
							16'd2: first_q[23:16] <= in_data.data_byte;
							16'd3: first_q[31:24] <= in_data.data_byte;
							default: ;
						endcase
					end
				end
				S_BYTE: begin
					seen_q <= seen_n;
					if (seen_q[5:0] != 6'd63 && {16'd0, seen_n} == len_q) busy_q <= 1'b0;
				end
				S_PAD: begin
					two_q <= pos > 6'd55;
					zi_q <= 4'(pos[5:2] + 4'd1);
				end
				S_ZERO: zi_q <= zi_q + 4'd1;
				S_COMP_WAIT: begin
					if (sts.done) begin
						if (busy_q && {16'd0, seen_q} == len_q) busy_q <= 1'b0;
						if (!busy_q && two_q) begin
							two_q <= 1'b0;
							zi_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) byte_q <= in_data.data_byte;
		if (state_q == S_BYTE) pad_q <= merged;
	end

	always_comb begin
		res_v = 1'b0;
		res = '0;
		if (state_q == S_IDLE && acc && in_data.operation == OP_START) begin
			if (magic_q != MAGIC_VALUE) begin
				res_v = 1'b1; res.status = ST_BAD_MAGIC;
			end else if (len_q == 32'd0 || len_q > 32'(MAX_IMAGE_BYTES)) begin
				res_v = 1'b1; res.status = ST_BAD_LEN;
			end
		end else if (state_q == S_REPORT) begin
			res_v = 1'b1;
			res.computed_crc = ~crc_q;
			if (seen_q < 16'd4 || (first_q & SP_MASK) != SP_BASE) res.status = ST_BAD_SP;
			else if (~crc_q != ecrc_q) res.status = ST_BAD_CRC;
			else if (digest != {dig_q[0], dig_q[1], dig_q[2], dig_q[3]})
				res.status = ST_BAD_DIGEST;
			else res.status = ST_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_v) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_v) out_data <= res;
	end

	fiv_sha_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .blk_word(rd_s1),
		.blk_addr(core_addr), .sts(sts), .digest(digest)
	);
endmodule

// ----- sv/fiv_checker.sv -----
`include "firmware_image_verifier_defines.svh"
module fiv_checker import fiv_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	`FIV_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result beat changed under stall")
	`FIV_ASSERT(a_status_range, clk, arst_n, out_valid |-> out_data.status <= ST_BAD_DIGEST, "status out of range")
	`FIV_ASSERT(a_early_crc, clk, arst_n, out_valid && (out_data.status == ST_BAD_MAGIC || out_data.status == ST_BAD_LEN) |-> out_data.computed_crc == 32'd0, "start failure with crc")
	`FIV_ASSERT(a_held_blocks_in, clk, arst_n, out_valid && out_stall |-> in_stall, "input taken while result held")
	`FIV_ASSERT_NR(a_reset_out, clk, !arst_n |=> !out_valid || arst_n, "result during reset")
endmodule

bind firmware_image_verifier fiv_checker u_fiv_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
